### hw/rtl/rhc_pkg.sv
// Shared types, constants and codes for the reference-counted handle cache.
package rhc_pkg;

	localparam int ENTRIES     = 16;
	localparam int HANDLE_BITS = 32;
	localparam int COUNT_BITS  = 16;
	localparam int COLOR_BITS  = 31;
	localparam int OUT_BITS    = 32;
	localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KEY_BITS    = (HANDLE_BITS > COLOR_BITS) ? HANDLE_BITS : COLOR_BITS;

	typedef logic [IDX_BITS-1:0]    idx_t;
	typedef logic [COLOR_BITS-1:0]  color_t;
	typedef logic [HANDLE_BITS-1:0] handle_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [KEY_BITS-1:0]    key_t;
	typedef logic [OUT_BITS-1:0]    out_word_t;

	localparam idx_t   LAST_IDX  = idx_t'(ENTRIES - 1);
	localparam count_t COUNT_ONE = count_t'(1);
	localparam count_t COUNT_MAX = '1;

	typedef enum logic {
		ACT_GET     = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		OC_HIT      = 3'd0,
		OC_DUP      = 3'd1,
		OC_INSERT   = 3'd2,
		OC_FULL     = 3'd3,
		OC_RELEASED = 3'd4,
		OC_NOTFOUND = 3'd5,
		OC_NULL     = 3'd6
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_COLOR,
		ST_SCAN_HANDLE,
		ST_PROBE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic    we_entry;
		logic    we_uses;
		idx_t    idx;
		color_t  color;
		handle_t handle;
		count_t  uses;
	} tbl_wr_t;

	typedef struct packed {
		out_word_t result_handle;
		outcome_t  outcome;
		logic      delete_valid;
		out_word_t delete_handle;
	} result_t;

endpackage

### hw/rtl/rhc_table.sv
// Entry table: color, handle and use count per slot, one read and one write port.
module rhc_table (
	input  logic            clk,
	input  logic            arst_n,
	input  rhc_pkg::idx_t   rd_idx,
	input  rhc_pkg::tbl_wr_t wr,
	output rhc_pkg::color_t rd_color,
	output rhc_pkg::handle_t rd_handle,
	output rhc_pkg::count_t rd_uses
);
	import rhc_pkg::*;

	color_t  color_q  [ENTRIES];
	handle_t handle_q [ENTRIES];
	count_t  uses_q   [ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				handle_q[i] <= '0;
				uses_q[i]   <= '0;
			end
		end else begin
			if (wr.we_entry) begin
				handle_q[wr.idx] <= wr.handle;
			end
			if (wr.we_uses) begin
				uses_q[wr.idx] <= wr.uses;
			end
		end
	end

	// A slot with a null handle never matches on color, so colors need no reset.
	always_ff @(posedge clk) begin
		if (wr.we_entry) begin
			color_q[wr.idx] <= wr.color;
		end
	end

	assign rd_color  = color_q[rd_idx];
	assign rd_handle = handle_q[rd_idx];
	assign rd_uses   = uses_q[rd_idx];

endmodule

### hw/rtl/rhc_unit.sv
// Shared key comparator and saturating use-count incrementer/decrementer.
module rhc_unit (
	input  rhc_pkg::key_t   key_a,
	input  rhc_pkg::key_t   key_b,
	input  rhc_pkg::count_t count_in,
	input  logic            dec,
	output logic            key_eq,
	output logic            count_zero,
	output rhc_pkg::count_t count_next
);
	import rhc_pkg::*;

	always_comb begin
		key_eq     = (key_a == key_b);
		count_zero = (count_in == '0);
		if (dec) begin
			count_next = count_zero ? count_in : count_in - COUNT_ONE;
		end else begin
			count_next = (count_in == COUNT_MAX) ? count_in : count_in + COUNT_ONE;
		end
	end

endmodule

### hw/rtl/rhc_ctrl.sv
// Sequencer that walks the table one slot per cycle for lookups and replacement.
module rhc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic             req_action,
	input  rhc_pkg::color_t  req_color,
	input  rhc_pkg::handle_t req_handle,
	input  logic             out_free,
	output logic             res_valid,
	output rhc_pkg::result_t res,
	output logic             busy
);
	import rhc_pkg::*;

	state_t  state_q, state_d;
	idx_t    idx_q, n_q, ptr_q, ptr_next, rd_idx;
	action_t act_q;
	color_t  color_q;
	handle_t hnd_q;
	result_t res_q, res_d;
	logic    res_load;
	logic    last_idx, last_n;
	tbl_wr_t wr;
	color_t  rd_color;
	handle_t rd_handle;
	count_t  rd_uses, count_next;
	key_t    key_a, key_b;
	logic    key_eq, count_zero;

	rhc_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_idx    (rd_idx),
		.wr        (wr),
		.rd_color  (rd_color),
		.rd_handle (rd_handle),
		.rd_uses   (rd_uses)
	);

	rhc_unit u_unit (
		.key_a      (key_a),
		.key_b      (key_b),
		.count_in   (rd_uses),
		.dec        (act_q == ACT_RELEASE),
		.key_eq     (key_eq),
		.count_zero (count_zero),
		.count_next (count_next)
	);

	assign last_idx = (idx_q == LAST_IDX);
	assign last_n   = (n_q == LAST_IDX);
	assign ptr_next = (ptr_q == LAST_IDX) ? '0 : ptr_q + idx_t'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (action_t'(req_action) == ACT_RELEASE) begin
						state_d = (req_handle == '0) ? ST_DONE : ST_SCAN_HANDLE;
					end else begin
						state_d = ST_SCAN_COLOR;
					end
				end
			end
			ST_SCAN_COLOR: begin
				if (key_eq && rd_handle != '0) begin
					state_d = ST_DONE;
				end else if (last_idx) begin
					state_d = (hnd_q == '0) ? ST_DONE : ST_SCAN_HANDLE;
				end
			end
			ST_SCAN_HANDLE: begin
				if (key_eq) begin
					state_d = ST_DONE;
				end else if (last_idx) begin
					state_d = (act_q == ACT_RELEASE) ? ST_DONE : ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (count_zero || last_n) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == ST_IDLE);
		res_valid = (state_q == ST_DONE);
		busy      = (state_q != ST_IDLE);
		rd_idx    = idx_q;
		key_a     = '0;
		key_b     = '0;
		wr        = '0;
		res_load  = 1'b0;
		res_d     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && action_t'(req_action) == ACT_RELEASE && req_handle == '0) begin
					res_load      = 1'b1;
					res_d.outcome = OC_NULL;
				end
			end
			ST_SCAN_COLOR: begin
				key_a = key_t'(color_q);
				key_b = key_t'(rd_color);
				if (key_eq && rd_handle != '0) begin
					wr.we_uses          = 1'b1;
					wr.idx              = idx_q;
					wr.uses             = count_next;
					res_load            = 1'b1;
					res_d.result_handle = OUT_BITS'(rd_handle);
					res_d.outcome       = OC_HIT;
				end else if (last_idx && hnd_q == '0) begin
					res_load      = 1'b1;
					res_d.outcome = OC_NULL;
				end
			end
			ST_SCAN_HANDLE: begin
				key_a = key_t'(hnd_q);
				key_b = key_t'(rd_handle);
				if (key_eq) begin
					wr.we_uses = 1'b1;
					wr.idx     = idx_q;
					wr.uses    = count_next;
					res_load   = 1'b1;
					if (act_q == ACT_RELEASE) begin
						res_d.outcome = OC_RELEASED;
					end else begin
						res_d.outcome       = OC_DUP;
						res_d.result_handle = OUT_BITS'(hnd_q);
					end
				end else if (last_idx && act_q == ACT_RELEASE) begin
					res_load            = 1'b1;
					res_d.outcome       = OC_NOTFOUND;
					res_d.delete_valid  = 1'b1;
					res_d.delete_handle = OUT_BITS'(hnd_q);
				end
			end
			ST_PROBE: begin
				rd_idx = ptr_next;
				if (count_zero) begin
					wr.we_entry         = 1'b1;
					wr.we_uses          = 1'b1;
					wr.idx              = ptr_next;
					wr.color            = color_q;
					wr.handle           = hnd_q;
					wr.uses             = COUNT_ONE;
					res_load            = 1'b1;
					res_d.result_handle = OUT_BITS'(hnd_q);
					res_d.outcome       = OC_INSERT;
					res_d.delete_valid  = (rd_handle != '0);
					res_d.delete_handle = OUT_BITS'(rd_handle);
				end else if (last_n) begin
					res_load            = 1'b1;
					res_d.result_handle = OUT_BITS'(hnd_q);
					res_d.outcome       = OC_FULL;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			n_q     <= '0;
			ptr_q   <= LAST_IDX;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					n_q   <= '0;
				end
				ST_SCAN_COLOR, ST_SCAN_HANDLE: begin
					idx_q <= last_idx ? '0 : idx_q + idx_t'(1);
				end
				ST_PROBE: begin
					n_q   <= n_q + idx_t'(1);
					ptr_q <= ptr_next;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			act_q   <= action_t'(req_action);
			color_q <= req_color;
			hnd_q   <= req_handle;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

### hw/rtl/refcounted_handle_cache_top.sv
// Top level of the reference-counted handle cache with stream ports.
// Each request is handled by a sequencer that reads one table slot per cycle through
// a single read port and one shared comparator: a get scans the slots for its color,
// then on a miss for its handle, and then probes for a slot with a zero use count to
// insert into (or reports full); a release scans for its handle only, and a null
// release needs no scan. The request port is ready only while the sequencer is idle,
// and a finished result waits in the output register so that a new request can be
// taken while it is still unread.
module refcounted_handle_cache_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // color[30:0], handle[62:31], zero pad[63]
	input  logic        s_tuser,  // action[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // result_handle[31:0], outcome[34:32],
	                              // delete_valid[35], delete_handle[67:36], zero pad[71:68]
);
	import rhc_pkg::*;

	logic        out_free, res_valid, busy;
	result_t     res;
	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;

	assign out_free = !m_tvalid_q || m_tready;

	rhc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_tvalid),
		.req_ready  (s_tready),
		.req_action (s_tuser),
		.req_color  (s_tdata[30:0]),
		.req_handle (handle_t'(s_tdata[62:31])),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res),
		.busy       (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			m_tdata_q <= {4'b0, res.delete_handle, res.delete_valid, res.outcome,
				res.result_handle};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (busy && !s_tready))
		else $error("Request accepted while the sequencer stayed idle.");

	a_delete_handle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[35]) |-> (m_tdata[67:36] == '0))
		else $error("Delete handle is nonzero without delete_valid.");

	a_release_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (outcome_t'(m_tdata[34:32]) == OC_RELEASED
			|| outcome_t'(m_tdata[34:32]) == OC_NOTFOUND
			|| outcome_t'(m_tdata[34:32]) == OC_NULL)) |-> (m_tdata[31:0] == '0))
		else $error("Release or null result carries a result handle.");
`endif

endmodule

### test/tb_refcounted_handle_cache_top.sv
// Self-checking testbench for the reference-counted handle cache with stream ports.
module tb_refcounted_handle_cache_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rhc_pkg::*;

	localparam int     IDLE_LIMIT      = 4000;
	localparam int     RANDOM_REQUESTS = 1100;
	localparam int     SAT_GETS        = 200;
	localparam int     SAT_RELEASES    = 205;
	localparam int     MAX_REPORTS     = 10;
	localparam int     COLOR_POOL      = 24;
	localparam int     HANDLE_POOL     = 48;
	localparam color_t  SAT_COLOR      = 31'h2AAAAAAA;
	localparam handle_t SAT_HANDLE     = 32'h55555555;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_MOSTLY,
		RX_SLOTTED
	} rx_mode_t;

	class cache_result_board;
		color_t  slot_color [ENTRIES];
		handle_t slot_handle[ENTRIES];
		count_t  slot_uses  [ENTRIES];
		idx_t    fill_ptr;
		result_t expected_results[$];
		int      mismatch_count;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				slot_color[i]  = '0;
				slot_handle[i] = '0;
				slot_uses[i]   = '0;
			end
			fill_ptr       = LAST_IDX;
			mismatch_count = 0;
		endfunction

		function int slot_of_handle(handle_t hnd);
			int s;
			s = -1;
			for (int i = 0; i < ENTRIES && s < 0; i++)
				if (slot_handle[i] == hnd) s = i;
			return s;
		endfunction

		function void bump_uses(int s);
			if (slot_uses[s] != COUNT_MAX) slot_uses[s]++;
		endfunction

		function void predict_request(action_t act, color_t col, handle_t hnd);
			result_t r;
			int      s;
			bit      placed;
			r = '0;
			if (act == ACT_RELEASE) begin
				if (hnd == '0) begin
					r.outcome = OC_NULL;
				end else begin
					s = slot_of_handle(hnd);
					if (s >= 0) begin
						if (slot_uses[s] != '0) slot_uses[s]--;
						r.outcome = OC_RELEASED;
					end else begin
						r.outcome       = OC_NOTFOUND;
						r.delete_valid  = 1'b1;
						r.delete_handle = out_word_t'(hnd);
					end
				end
			end else begin
				s = -1;
				for (int i = 0; i < ENTRIES && s < 0; i++)
					if (slot_handle[i] != '0 && slot_color[i] == col) s = i;
				if (s >= 0) begin
					bump_uses(s);
					r.outcome       = OC_HIT;
					r.result_handle = out_word_t'(slot_handle[s]);
				end else if (hnd == '0) begin
					r.outcome = OC_NULL;
				end else begin
					s = slot_of_handle(hnd);
					r.result_handle = out_word_t'(hnd);
					if (s >= 0) begin
						bump_uses(s);
						r.outcome = OC_DUP;
					end else begin
						placed    = 1'b0;
						r.outcome = OC_FULL;
						for (int n = 0; n < ENTRIES && !placed; n++) begin
							fill_ptr = (fill_ptr == LAST_IDX) ? idx_t'(0) : fill_ptr + 1'b1;
							if (slot_uses[fill_ptr] == '0) begin
								placed          = 1'b1;
								r.outcome       = OC_INSERT;
								r.delete_valid  = (slot_handle[fill_ptr] != '0);
								r.delete_handle = out_word_t'(slot_handle[fill_ptr]);
								slot_handle[fill_ptr] = hnd;
								slot_color[fill_ptr]  = col;
								slot_uses[fill_ptr]   = COUNT_ONE;
							end
						end
					end
				end
			end
			expected_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			bit      bad;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: handle %h outcome %0d delete %0b/%h",
						got.result_handle, got.outcome, got.delete_valid, got.delete_handle);
			end else begin
				want = expected_results.pop_front();
				bad  = 1'b0;
				if (got.result_handle != want.result_handle) bad = 1'b1;
				if (got.outcome != want.outcome) bad = 1'b1;
				if (got.delete_valid != want.delete_valid) bad = 1'b1;
				if (got.delete_handle != want.delete_handle) bad = 1'b1;
				if (bad) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"mismatch: expected handle %h outcome %0d delete %0b/%h,",
							" got handle %h outcome %0d delete %0b/%h"},
							want.result_handle, want.outcome, want.delete_valid,
							want.delete_handle, got.result_handle, got.outcome,
							got.delete_valid, got.delete_handle);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;

	cache_result_board board;
	color_t            color_pool [COLOR_POOL];
	handle_t           handle_pool[HANDLE_POOL];
	bit                pacing      = 1'b1;
	bit                rx_open     = 1'b0;
	int                burst_left  = 1;
	int                idle_cycles = 0;
	int                rx_left     = 0;
	rx_mode_t          rx_mode     = RX_OPEN;
	bit                rx_ready;

	refcounted_handle_cache_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // color[30:0], handle[62:31], zero pad[63]
		.s_tuser  (s_tuser),   // action[0]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // result_handle[31:0], outcome[34:32],
		                       // delete_valid[35], delete_handle[67:36], zero pad[71:68]
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 300);
		end else
			rx_left--;
		case (rx_mode)
			RX_OPEN: rx_ready = 1'b1;
			RX_COIN: rx_ready = $urandom_range(0, 1);
			RX_MOSTLY: rx_ready = ($urandom_range(0, 7) != 0);
			default: rx_ready = (rx_left % 16) < 3;
		endcase
		m_tready <= rx_open || rx_ready;
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.predict_request(action_t'(s_tuser), s_tdata[30:0], s_tdata[62:31]);
			if (m_tvalid && m_tready) begin
				got.result_handle = m_tdata[31:0];
				got.outcome       = outcome_t'(m_tdata[34:32]);
				got.delete_valid  = m_tdata[35];
				got.delete_handle = m_tdata[67:36];
				board.check_result(got);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_request(input action_t act, input color_t col, input handle_t hnd);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {1'b0, hnd, col};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (pacing) begin
			burst_left--;
			if (burst_left <= 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic color_t pick_color();
		if ($urandom_range(1, 100) <= 15) return color_t'($urandom);
		return color_pool[$urandom_range(0, COLOR_POOL - 1)];
	endfunction

	function automatic handle_t pick_handle();
		int r;
		r = $urandom_range(1, 100);
		if (r <= 5) return '0;
		if (r <= 20) return handle_t'($urandom);
		return handle_pool[$urandom_range(0, HANDLE_POOL - 1)];
	endfunction

	initial begin
		int release_pct;
		board = new();
		for (int i = 0; i < COLOR_POOL; i++) color_pool[i] = color_t'($urandom);
		for (int i = 0; i < HANDLE_POOL; i++) begin
			handle_pool[i] = handle_t'($urandom);
			if (handle_pool[i] == '0) handle_pool[i] = handle_t'(1);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(ACT_RELEASE, '0, '0);
		send_request(ACT_RELEASE, 31'h7FFFFFFF, 32'hFFFFFFFF);
		send_request(ACT_GET, '0, '0);
		send_request(ACT_GET, '0, 32'hFFFFFFFF);
		send_request(ACT_GET, '0, 32'h00000001);
		send_request(ACT_GET, 31'h7FFFFFFF, 32'hFFFFFFFF);
		send_request(ACT_GET, 31'h7FFFFFFF, 32'h00000001);
		repeat (4) send_request(ACT_RELEASE, '0, 32'hFFFFFFFF);
		for (int i = 0; i < ENTRIES - 2; i++)
			send_request(ACT_GET, color_t'(32'h100 + i), handle_t'(32'h1000 + i));
		send_request(ACT_GET, SAT_COLOR, SAT_HANDLE);
		send_request(ACT_GET, 31'h12345678, 32'h80000000);
		pause_until_drained();

		// Raise one slot's count well above one, then release it past zero.
		pacing  = 1'b0;
		rx_open = 1'b1;
		repeat (SAT_GETS) send_request(ACT_GET, SAT_COLOR, handle_t'($urandom));
		repeat (SAT_RELEASES) send_request(ACT_RELEASE, color_t'($urandom), SAT_HANDLE);
		send_request(ACT_GET, 31'h0ABCDEF0, 32'h0F0F0F0F);
		pause_until_drained();
		pacing  = 1'b1;
		rx_open = 1'b0;

		release_pct = 30;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 100 == 0) release_pct = $urandom_range(15, 55);
			if (n % 400 == 399) pause_until_drained();
			if ($urandom_range(1, 100) <= release_pct)
				send_request(ACT_RELEASE, color_t'($urandom), pick_handle());
			else
				send_request(ACT_GET, pick_color(), pick_handle());
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.expected_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (board.expected_results.size() != 0) begin
			board.mismatch_count++;
			$display("%0d expected results never arrived", board.expected_results.size());
		end
		if (board.mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
